// ===== rtl/depth_frame_ring_quantizer_assert.svh =====
// ----------------------------------------------------------------------------
// depth frame ring quantizer assertion macros
// shared property wrappers for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef DEPTH_FRAME_RING_QUANTIZER_ASSERT_SVH
`define DEPTH_FRAME_RING_QUANTIZER_ASSERT_SVH

// check that is switched off while reset is applied
`define DFRQ_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define DFRQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dfrq_pkg.sv =====
// ----------------------------------------------------------------------------
// dfrq_pkg
// types, codes and defaults shared by the depth frame ring quantizer
// ----------------------------------------------------------------------------
`default_nettype none

package dfrq_pkg;

    // default sizes of the frame ring
    localparam int FRAMES_DEF     = 20;
    localparam int SIDE_DEF       = 24;
    localparam int DEPTH_BITS_DEF = 12;

    // fixed field widths
    localparam int GAIN_W    = 24;
    localparam int ZP_W      = 8;
    localparam int CFG_W     = 24;
    localparam int FRAC_BITS = 16;

    // depth clamp in millimetres
    localparam int DEPTH_LIMIT = 2550;

    // configuration reset values
    localparam logic [GAIN_W-1:0]        GAIN_RESET = 24'd6554;
    localparam logic signed [ZP_W-1:0]   ZP_RESET   = -8'sd128;

    // item function codes
    typedef enum logic [1:0] {
        FN_WRITE     = 2'd0,
        FN_END_FRAME = 2'd1,
        FN_READ      = 2'd2,
        FN_RESET     = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_DROPPED   = 2'd2
    } status_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_GAIN = 1'd0,
        REG_ZP   = 1'd1
    } reg_index_t;

    // input transaction
    typedef struct packed {
        func_t       func;
        logic [4:0]  row_sel;
        logic [4:0]  col_sel;
        logic [4:0]  frame_age;
        logic [15:0] depth_mm;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic signed [7:0] quantized;
        status_t           status;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/depth_frame_ring_quantizer.sv =====
// ----------------------------------------------------------------------------
// depth_frame_ring_quantizer
// ring of depth frames in one block memory with int8 quantized read-out
// ----------------------------------------------------------------------------
//  channel   signals                          transaction
//  in        in_valid, in_ready, in_item      one pixel write, end frame, read or reset
//  out       out_valid, out_ready, out_item   one result for every input transaction
//  cfg       cfg_we, cfg_index, cfg_data      register write, no handshake
//
//  every result is registered after acceptance by the store read, gain multiply,
//  then zero point and saturation into the output register; one item is in the
//  pipe at a time, so a new item is taken only once both stages are empty, set by
//  in_ready staying low while either pipe stage holds an item.
//  a result waiting in the output register does not hold off the next item; that
//  item stalls in the last stage. reset clears counts and the pipe; the store has
//  no clearing pass and holds undefined data until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "depth_frame_ring_quantizer_assert.svh"

module depth_frame_ring_quantizer
    import dfrq_pkg::*;
#(
    parameter int FRAMES     = FRAMES_DEF,
    parameter int SIDE       = SIDE_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item,
    input  wire logic        cfg_we,
    input  wire reg_index_t  cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int FRAME_CELLS = SIDE * SIDE;
    localparam int CELLS       = FRAMES * FRAME_CELLS;
    localparam int AW          = $clog2(CELLS);
    localparam int SLOT_W      = $clog2(FRAMES);
    localparam int HELD_W      = $clog2(FRAMES + 1);
    localparam int PW          = DEPTH_BITS + GAIN_W;
    localparam int TOP_DEPTH   = (1 << DEPTH_BITS) - 1;
    localparam int CLAMP       = (TOP_DEPTH < DEPTH_LIMIT) ? TOP_DEPTH : DEPTH_LIMIT;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAMES - 1);
    localparam logic [HELD_W-1:0] FULL      = HELD_W'(FRAMES);

    // configuration registers
    logic [GAIN_W-1:0]      gain_reg;
    logic signed [ZP_W-1:0] zp_reg;

    // ring pointers
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [HELD_W-1:0] frames_held_reg, frames_held_next;

    // frame store
    logic [DEPTH_BITS-1:0] store_mem [CELLS];
    logic [DEPTH_BITS-1:0] rd_data_reg;

    // pipe stages
    logic          s1_valid_reg, s2_valid_reg;
    logic          s1_read_reg, s2_read_reg;
    status_t       s1_status_reg, s2_status_reg;
    logic [PW-1:0] prod_reg;
    logic          out_valid_reg;
    out_item_t     out_item_reg;

    logic                  accept;
    logic                  s2_move;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [DEPTH_BITS-1:0] wr_data;
    logic                  read_ok;
    status_t               acc_status;
    logic [SLOT_W-1:0]     age_mod [32];
    logic [SLOT_W:0]       slot_sum;
    logic [SLOT_W-1:0]     rd_slot;
    logic signed [7:0]     q_val;

    assign in_ready  = !s1_valid_reg && !s2_valid_reg;
    assign accept    = in_valid && in_ready;
    assign s2_move   = s2_valid_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // frame age reduced modulo the ring size
    for (genvar g = 0; g < 32; g++)
    begin : g_age
        assign age_mod[g] = SLOT_W'(g % FRAMES);
    end

    // slot of a read, oldest first from the write pointer
    assign slot_sum = {1'b0, write_slot_reg} + {1'b0, age_mod[in_item.frame_age]};
    assign rd_slot  = (slot_sum >= (SLOT_W+1)'(FRAMES)) ?
                      SLOT_W'(slot_sum - (SLOT_W+1)'(FRAMES)) : slot_sum[SLOT_W-1:0];

    // addresses: write rotated clockwise, read in output order
    assign wr_addr = AW'(write_slot_reg) * AW'(FRAME_CELLS)
                   + AW'(in_item.col_sel) * AW'(SIDE)
                   + (AW'(SIDE) - AW'(in_item.row_sel));
    assign rd_addr = AW'(rd_slot) * AW'(FRAME_CELLS)
                   + AW'(in_item.row_sel) * AW'(SIDE)
                   + AW'(in_item.col_sel);

    // clamp of the incoming depth
    assign wr_data = (in_item.depth_mm > 16'(CLAMP)) ? DEPTH_BITS'(CLAMP)
                                                     : in_item.depth_mm[DEPTH_BITS-1:0];

    // decode of the accepted transaction
    always_comb
    begin
        wr_en            = 1'b0;
        read_ok          = 1'b0;
        acc_status       = ST_OK;
        write_slot_next  = write_slot_reg;
        frames_held_next = frames_held_reg;
        case (in_item.func)
            FN_WRITE:
            begin
                if ((in_item.row_sel == 5'd0) || (in_item.row_sel > SIDE)
                    || (in_item.col_sel >= SIDE))
                begin
                    acc_status = ST_DROPPED;
                end
                else
                begin
                    wr_en = accept;
                end
            end
            FN_END_FRAME:
            begin
                write_slot_next = (write_slot_reg == LAST_SLOT) ? '0
                                : write_slot_reg + 1'b1;
                if (frames_held_reg != FULL)
                begin
                    frames_held_next = frames_held_reg + 1'b1;
                end
            end
            FN_READ:
            begin
                if (frames_held_reg != FULL)
                begin
                    acc_status = ST_NOT_READY;
                end
                else if ((in_item.row_sel >= SIDE) || (in_item.col_sel >= SIDE))
                begin
                    acc_status = ST_DROPPED;
                end
                else
                begin
                    read_ok = 1'b1;
                end
            end
            FN_RESET:
            begin
                write_slot_next  = '0;
                frames_held_next = '0;
            end
            default:
            begin
                acc_status = ST_OK;
            end
        endcase
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            zp_reg   <= ZP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                REG_ZP:   zp_reg   <= cfg_data[ZP_W-1:0];
                default:  gain_reg <= gain_reg;
            endcase
        end
    end

    // ring pointers and pipe control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            frames_held_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                write_slot_reg  <= write_slot_next;
                frames_held_reg <= frames_held_next;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pipe payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg   <= read_ok;
            s1_status_reg <= acc_status;
        end
        if (s1_valid_reg)
        begin
            s2_read_reg   <= s1_read_reg;
            s2_status_reg <= s1_status_reg;
            prod_reg      <= rd_data_reg * gain_reg;
        end
        if (s2_move)
        begin
            out_item_reg.quantized <= s2_read_reg ? q_val : 8'sd0;
            out_item_reg.status    <= s2_status_reg;
        end
    end

    // zero point, truncation and saturation
    dfrq_quant #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_quant (
        .product    (prod_reg),
        .zp_value   (zp_reg),
        .quantized  (q_val)
    );

    // checks
    `DFRQ_ASSERT_RUN(a_pipe_advance, s1_valid_reg |=> s2_valid_reg, "stage one item lost")
    `DFRQ_ASSERT_RUN(a_held_bound, frames_held_reg <= FULL, "frame count above ring size")
    `DFRQ_ASSERT_RUN(a_slot_bound, write_slot_reg <= LAST_SLOT, "write slot out of ring")
    `DFRQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")
    `DFRQ_ASSERT_RUN(a_zero_on_fail,
        (out_valid && (out_item.status != ST_OK)) |-> (out_item.quantized == 8'sd0),
        "nonzero value on a failed transaction")

endmodule

`default_nettype wire

// ===== rtl/dfrq_quant.sv =====
// ----------------------------------------------------------------------------
// dfrq_quant
// adds the zero point to a scaled depth, truncates toward zero, saturates to int8
// ----------------------------------------------------------------------------
`default_nettype none

module dfrq_quant
    import dfrq_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  wire logic [DEPTH_BITS+GAIN_W-1:0] product,
    input  wire logic signed [ZP_W-1:0]       zp_value,
    output logic signed [7:0]                 quantized
);

    localparam int PW = DEPTH_BITS + GAIN_W;
    localparam int VW = PW + 2;
    localparam logic signed [VW-1:0] QMIN = VW'(-128);
    localparam logic signed [VW-1:0] QMAX = VW'(127);

    logic signed [VW-1:0] zp_ext;
    logic signed [VW-1:0] value;
    logic signed [VW-1:0] floor_val;
    logic signed [VW-1:0] trunc_val;
    logic                 round_up;

    // zero point moved onto the fraction grid
    assign zp_ext = {{(VW-ZP_W-FRAC_BITS){zp_value[ZP_W-1]}}, zp_value, {FRAC_BITS{1'b0}}};
    assign value  = $signed({2'b00, product}) + zp_ext;

    // floor shift, then step up for negative values with a fraction left
    assign floor_val = value >>> FRAC_BITS;
    assign round_up  = value[VW-1] && (|value[FRAC_BITS-1:0]);
    assign trunc_val = floor_val + $signed({{(VW-1){1'b0}}, round_up});

    // saturate to the int8 range
    always_comb
    begin
        if (trunc_val < QMIN)
        begin
            quantized = -8'sd128;
        end
        else if (trunc_val > QMAX)
        begin
            quantized = 8'sd127;
        end
        else
        begin
            quantized = trunc_val[7:0];
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for depth_frame_ring_quantizer
// drives pixel writes, end frames, quantized reads and count resets through the
// valid/ready input channel, predicts every answer with a local copy of the
// frame ring and the gain/zero point registers, and checks each transaction
// on the result channel in order; both sides idle and stall at random
// ----------------------------------------------------------------------------
module testbench;
    import dfrq_pkg::*;

    localparam int FRAMES     = FRAMES_DEF;
    localparam int SIDE       = SIDE_DEF;
    localparam int DEPTH_BITS = DEPTH_BITS_DEF;
    localparam int CELLS      = FRAMES * SIDE * SIDE;
    localparam int MAX_SHOWN  = 30;

    // clock, reset and block ports
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    in_item_t         in_item   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_item;
    logic             cfg_we    = 1'b0;
    reg_index_t       cfg_index = REG_GAIN;
    logic [CFG_W-1:0] cfg_data  = '0;

    // local copy of the ring and the registers
    logic [DEPTH_BITS-1:0] depth_store [0:CELLS-1];
    bit                    cell_written [0:CELLS-1];
    int                    written_cells [$];
    int                    wr_slot = 0;
    int                    held    = 0;
    logic [GAIN_W-1:0]     gain_q  = GAIN_RESET;
    logic signed [ZP_W-1:0] zp_q   = ZP_RESET;

    // answers still owed by the block, oldest first
    out_item_t due_answers [$];

    // run bookkeeping
    int  errors     = 0;
    int  checked    = 0;
    int  n_writes   = 0;
    int  n_cropped  = 0;
    int  n_frames   = 0;
    int  n_resets   = 0;
    int  n_reads    = 0;
    int  n_refused  = 0;
    int  n_bad_idx  = 0;
    bit  quiet_run  = 1'b0;

    always #2 clk = ~clk;

    depth_frame_ring_quantizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (quiet_run)
            return 0;
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // int8 value of a stored depth under the current gain and zero point
    function automatic logic signed [7:0] quantize_depth(input logic [DEPTH_BITS-1:0] d);
        longint v;
        longint t;
        v = longint'(d) * longint'(gain_q) + longint'(zp_q) * 65536;
        if (v >= 0)
            t = v >>> FRAC_BITS;
        else
            t = -((-v) >>> FRAC_BITS);
        if (t < -128)
            t = -128;
        if (t > 127)
            t = 127;
        return t[7:0];
    endfunction

    // answer of one transaction; updates the local ring
    function automatic out_item_t ring_answer(input in_item_t it);
        out_item_t res;
        int        row;
        int        col;
        int        age;
        int        addr;
        int        lim;
        row = it.row_sel;
        col = it.col_sel;
        age = it.frame_age;
        res.quantized = '0;
        res.status    = ST_OK;
        lim = (2 ** DEPTH_BITS) - 1;
        if (DEPTH_LIMIT < lim)
            lim = DEPTH_LIMIT;
        case (it.func)
            FN_WRITE:
            begin
                n_writes++;
                if (row == 0 || row > SIDE || col >= SIDE)
                begin
                    res.status = ST_DROPPED;
                    n_cropped++;
                end
                else
                begin
                    // rotate clockwise: source (r, c) lands at row c, column SIDE - r
                    addr = (wr_slot * SIDE + col) * SIDE + (SIDE - row);
                    depth_store[addr] = DEPTH_BITS'((int'(it.depth_mm) > lim) ? lim
                                                    : int'(it.depth_mm));
                    if (!cell_written[addr])
                    begin
                        cell_written[addr] = 1'b1;
                        written_cells.push_back(addr);
                    end
                end
            end
            FN_END_FRAME:
            begin
                n_frames++;
                wr_slot = (wr_slot + 1) % FRAMES;
                if (held < FRAMES)
                    held++;
            end
            FN_READ:
            begin
                if (held < FRAMES)
                begin
                    res.status = ST_NOT_READY;
                    n_refused++;
                end
                else if (row >= SIDE || col >= SIDE)
                begin
                    res.status = ST_DROPPED;
                    n_bad_idx++;
                end
                else
                begin
                    addr = (((wr_slot + age % FRAMES) % FRAMES) * SIDE + row) * SIDE + col;
                    res.quantized = quantize_depth(depth_store[addr]);
                    n_reads++;
                end
            end
            default:
            begin
                n_resets++;
                wr_slot = 0;
                held    = 0;
            end
        endcase
        return res;
    endfunction

    function automatic in_item_t mk_item(input func_t f, input int row, input int col,
                                         input int age, input int mm);
        in_item_t it;
        it.func      = f;
        it.row_sel   = 5'(row);
        it.col_sel   = 5'(col);
        it.frame_age = 5'(age);
        it.depth_mm  = 16'(mm);
        return it;
    endfunction

    // read of a cell that holds data, sometimes with a wrapped age; an out-of-range row when none is written
    function automatic in_item_t pick_written();
        in_item_t it;
        int       addr;
        int       age;
        it = mk_item(FN_READ, 0, 0, 0, $urandom_range(0, 65535));
        if (written_cells.size() == 0)
        begin
            it.row_sel = 5'(SIDE);
            return it;
        end
        addr = written_cells[$urandom_range(0, written_cells.size() - 1)];
        it.row_sel = 5'((addr / SIDE) % SIDE);
        it.col_sel = 5'(addr % SIDE);
        age = (addr / (SIDE * SIDE) - wr_slot + FRAMES) % FRAMES;
        if (age + FRAMES <= 31 && $urandom_range(0, 3) == 0)
            age += FRAMES;
        it.frame_age = 5'(age);
        return it;
    endfunction

    // keep a ready in-range read away from cells that were never written
    function automatic in_item_t steer_read(input in_item_t it);
        int addr;
        if (it.func != FN_READ || held < FRAMES || it.row_sel >= SIDE || it.col_sel >= SIDE)
            return it;
        addr = (((wr_slot + it.frame_age % FRAMES) % FRAMES) * SIDE + it.row_sel) * SIDE
               + it.col_sel;
        if (cell_written[addr])
            return it;
        return pick_written();
    endfunction

    // mostly well-formed traffic with random content, some noise
    function automatic in_item_t next_traffic();
        in_item_t    it;
        logic [63:0] raw;
        int          p;
        int          q;
        p = $urandom_range(0, 99);
        if (held < FRAMES)
            p = (p < 45) ? 10 : (p < 80) ? 45 : (p < 95) ? 70 : 99;
        if (p < 40)
        begin
            it = mk_item(FN_WRITE, $urandom_range(1, SIDE), $urandom_range(0, SIDE - 1),
                         $urandom_range(0, 31), 0);
            if ($urandom_range(0, 9) == 0)
            begin
                it.row_sel = 5'($urandom_range(0, 31));
                it.col_sel = 5'($urandom_range(0, 31));
            end
            q = $urandom_range(0, 9);
            if (q < 5)
                it.depth_mm = 16'($urandom_range(0, DEPTH_LIMIT));
            else if (q < 7)
                it.depth_mm = 16'($urandom_range(DEPTH_LIMIT - 10, DEPTH_LIMIT + 10));
            else
                it.depth_mm = 16'($urandom_range(0, 65535));
        end
        else if (p < 50)
            it = mk_item(FN_END_FRAME, 0, 0, 0, 0);
        else if (p < 94)
        begin
            if ($urandom_range(0, 4) != 0)
                it = pick_written();
            else
                it = mk_item(FN_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom_range(0, 65535));
        end
        else if (p < 95)
            it = mk_item(FN_RESET, 0, 0, 0, 0);
        else
        begin
            raw = {$urandom, $urandom};
            it  = raw[$bits(in_item_t)-1:0];
        end
        return steer_read(it);
    endfunction

    // one input transaction; valid stays high into the next call when there is no gap
    task automatic send_item(input in_item_t it);
        int gap;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        due_answers.push_back(ring_answer(it));
    endtask

    // drop valid and hold off until every owed answer has arrived
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GAIN)
            gain_q = val[GAIN_W-1:0];
        else
            zp_q = val[ZP_W-1:0];
    endtask

    task automatic set_quant(input logic [GAIN_W-1:0] g, input logic signed [ZP_W-1:0] z);
        wait_drained();
        write_reg(REG_GAIN, g);
        write_reg(REG_ZP, {{(CFG_W-ZP_W){z[ZP_W-1]}}, z});
    endtask

    // directed: field extremes, crop, not ready, count reset, saturation, wrap
    task automatic test_directed();
        send_item(mk_item(FN_READ, 0, 0, 0, 0));
        send_item(mk_item(FN_READ, 31, 31, 31, 65535));
        send_item(mk_item(FN_WRITE, 1, 0, 0, 0));
        send_item(mk_item(FN_WRITE, SIDE, SIDE - 1, 31, 65535));
        send_item(mk_item(FN_WRITE, 12, 5, 0, DEPTH_LIMIT));
        send_item(mk_item(FN_WRITE, 13, 6, 0, DEPTH_LIMIT + 1));
        send_item(mk_item(FN_WRITE, 2, 1, 0, 1));
        // crop: top row, rows past the sensor, a column past the sensor
        send_item(mk_item(FN_WRITE, 0, 3, 0, 100));
        send_item(mk_item(FN_WRITE, SIDE + 1, 3, 0, 100));
        send_item(mk_item(FN_WRITE, 31, 31, 0, 100));
        send_item(mk_item(FN_WRITE, 5, SIDE, 0, 100));
        repeat (3) send_item(mk_item(FN_END_FRAME, 0, 0, 0, 0));
        send_item(mk_item(FN_RESET, 31, 31, 31, 65535));
        send_item(mk_item(FN_READ, 0, SIDE - 1, 0, 0));
        // fill the ring back to the slot written above
        repeat (FRAMES) send_item(mk_item(FN_END_FRAME, 0, 0, 0, 0));
        send_item(mk_item(FN_READ, 0, SIDE - 1, 0, 0));
        send_item(mk_item(FN_READ, SIDE - 1, 0, FRAMES, 0));
        send_item(mk_item(FN_READ, 5, 12, 0, 0));
        send_item(mk_item(FN_READ, 6, 11, FRAMES, 0));
        send_item(mk_item(FN_READ, SIDE, 0, 0, 0));
        send_item(mk_item(FN_READ, 5, 31, 0, 0));
        // count saturates, slot moves on: the written slot is now the newest
        send_item(mk_item(FN_END_FRAME, 0, 0, 0, 0));
        send_item(mk_item(FN_READ, 0, SIDE - 1, FRAMES - 1, 0));
    endtask

    // register extremes against stored depths
    task automatic test_quant_extremes();
        logic [GAIN_W-1:0]      g;
        logic signed [ZP_W-1:0] z;
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0: begin g = '1;         z = 8'sd127;  end
                1: begin g = '0;         z = -8'sd128; end
                2: begin g = '1;         z = -8'sd128; end
                3: begin g = '0;         z = 8'sd127;  end
                4: begin g = 24'd1;      z = 8'sd0;    end
                default: begin g = GAIN_RESET; z = ZP_RESET; end
            endcase
            set_quant(g, z);
            repeat (12) send_item(pick_written());
        end
    endtask

    // random traffic in phases, each with its own quantizer setting
    task automatic test_random_traffic();
        logic [GAIN_W-1:0] g;
        int                q;
        for (int ph = 0; ph < 5; ph++)
        begin
            q = $urandom_range(0, 3);
            if (q < 2)
                g = 24'($urandom_range(1000, 20000));
            else if (q == 2)
                g = 24'($urandom_range(0, 1000));
            else
                g = 24'($urandom_range(0, 24'hFFFFFF));
            set_quant(g, 8'($urandom_range(0, 255)));
            quiet_run = (ph == 2);
            for (int n = 0; n < 90; n++)
            begin
                if (n == 45)
                    wait_drained();
                send_item(next_traffic());
            end
            quiet_run = 1'b0;
        end
    endtask

    // result side: random stalls of out_ready
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_run && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // compare each result transaction with the oldest owed answer
    always @(posedge clk)
    begin : answer_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_answers.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: unexpected result quantized %0d status %0d", $time,
                             out_item.quantized, out_item.status);
            end
            else
            begin
                want = due_answers.pop_front();
                checked++;
                if (out_item.quantized !== want.quantized || out_item.status !== want.status)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                    begin
                        if (out_item.quantized !== want.quantized)
                            $display("%0t: quantized mismatch, expected %0d, actual %0d",
                                     $time, want.quantized, out_item.quantized);
                        if (out_item.status !== want.status)
                            $display("%0t: status mismatch, expected %0d, actual %0d",
                                     $time, want.status, out_item.status);
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #2000000;
        $display("** depth_frame_ring_quantizer: FAILED **");
        $finish;
    end

    // main sequence
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_quant_extremes();
        test_random_traffic();
        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d writes (%0d cropped), %0d end frames, %0d count resets",
                 n_writes, n_cropped, n_frames, n_resets);
        $display("%0d quantized reads, %0d refused not ready, %0d bad index; %0d results checked",
                 n_reads, n_refused, n_bad_idx, checked);
        if (errors == 0)
            $display("** depth_frame_ring_quantizer: PASSED **");
        else
            $display("** depth_frame_ring_quantizer: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dfrq_pkg.sv
rtl/dfrq_quant.sv
rtl/depth_frame_ring_quantizer.sv
bench/testbench.sv
